### hw/rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the address resolution cache.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int MAX_WAITING_DEF   = 255;

  localparam logic [31:0] LOOPBACK_IP = 32'h7F00_0001;
  localparam logic [10:0] ARP_LEN     = 11'd46;
  localparam logic [15:0] PTYPE_IPV4  = 16'h0800;
  localparam logic [15:0] HTYPE_ETH   = 16'd1;
  localparam logic [7:0]  HLEN_ETH    = 8'd6;
  localparam logic [7:0]  PLEN_IPV4   = 8'd4;
  localparam logic [15:0] OP_REQUEST  = 16'd1;
  localparam logic [15:0] OP_REPLY    = 16'd2;
  localparam int          OUT_LIMIT   = 16;

  localparam logic [1:0] MODE_RESOLVE = 2'd0;
  localparam logic [1:0] MODE_PACKET  = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  localparam logic [3:0] K_RESOLVED  = 4'd0;
  localparam logic [3:0] K_QUEUED    = 4'd1;
  localparam logic [3:0] K_SEND_REQ  = 4'd2;
  localparam logic [3:0] K_SEND_REP  = 4'd3;
  localparam logic [3:0] K_RELEASE   = 4'd4;
  localparam logic [3:0] K_AGED      = 4'd5;
  localparam logic [3:0] K_LEARNED   = 4'd6;
  localparam logic [3:0] K_BAD_LEN   = 4'd7;
  localparam logic [3:0] K_BAD_TYPE  = 4'd8;
  localparam logic [3:0] K_BAD_OP    = 4'd9;
  localparam logic [3:0] K_NOT_ME    = 4'd10;
  localparam logic [3:0] K_FULL      = 4'd11;
  localparam logic [3:0] K_IGNORED   = 4'd12;

  localparam logic [2:0] REG_HOST_IP  = 3'd0;
  localparam logic [2:0] REG_HOST_MAC = 3'd1;
  localparam logic [2:0] REG_LIFETIME = 3'd2;
  localparam logic [2:0] REG_RETRY    = 3'd3;
  localparam logic [2:0] REG_TRIES    = 3'd4;
  localparam logic [2:0] REG_HOLDOFF  = 3'd5;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture input word
    logic scan_clr;   // reset scan pointer and match flags
    logic scan_step;  // examine the slot under the pointer
    logic tick_step;  // age/retry the slot under the pointer
    logic finish;     // act on the lookup result
    logic emit;       // load output register from pending result
  } arpc_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic scan_done;
    logic res_pending; // a result is waiting for emission
    logic tick_more;   // more slots remain in this tick and the result limit is not reached
    logic slot_hit;    // the slot under the pointer would give a tick result
  } arpc_sts_t;

endpackage

### hw/rtl/arp_cache_resolver.sv
// ----------------------------------------------------------------------------
// arp_cache_resolver
// Address resolution cache with lookup, learning, aging and retry.
// ----------------------------------------------------------------------------
// The input channel (in_valid/in_stall) carries one word per request: a
// resolve, a received ARP header, or a one-second tick. The output channel
// (out_valid/out_stall) carries result words; last marks the final word for
// an input. Resolve and packet words give exactly one result, after a lookup
// walk that examines one slot per cycle; a hit ends the walk early. The next
// word can be taken in the cycle after the result register is loaded. A tick
// walks the slots one per cycle while no held result blocks it, and holds
// each result until the walk finds the next one or ends, so that last is
// known when the word is sent. A tick whose walk finds nothing gives no word
// at all. One input is handled at a time; in_stall is high until the result
// register has been loaded with the final result, or until a tick walk that
// found nothing ends. A stalled receiver holds the output word, and a walk
// that has a new result ready waits for it. Reset empties the table, zeroes
// the clock and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module arp_cache_resolver #(
  parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_WAITING   = arpc_pkg::MAX_WAITING_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [31:0] ip_addr,
  input  logic [31:0] dest_ip,
  input  logic [47:0] src_mac,
  input  logic [15:0] hw_type,
  input  logic [15:0] proto_type,
  input  logic [7:0]  hw_len,
  input  logic [7:0]  proto_len,
  input  logic [15:0] operation,
  input  logic [10:0] pkt_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  kind,
  output logic [31:0] res_ip,
  output logic [47:0] res_mac,
  output logic [7:0]  waiting_count,
  output logic        last
);

  arpc_pkg::arpc_cmd_t cmd;
  arpc_pkg::arpc_sts_t sts;
  logic cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  arpc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_mode(mode),
    .out_busy(out_valid && out_stall), .sts, .in_stall, .cmd
  );

  arpc_dp #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_WAITING(MAX_WAITING)) u_dp (
    .clk, .rst, .cmd, .sts, .mode, .ip_addr, .dest_ip, .src_mac, .hw_type,
    .proto_type, .hw_len, .proto_len, .operation, .pkt_len,
    .cfg_we, .cfg_idx(paddr[5:3]), .cfg_wdata(pwdata), .cfg_rdata(prdata),
    .out_valid, .out_stall, .kind, .res_ip, .res_mac, .waiting_count, .last
  );

endmodule

### hw/rtl/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// arpc_ctrl
// Sequencer for lookups, table scans and result hand-off.
// ----------------------------------------------------------------------------
module arpc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_mode,
  input  logic               out_busy,
  input  arpc_pkg::arpc_sts_t sts,
  output logic               in_stall,
  output arpc_pkg::arpc_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_FIN, S_TICK, S_WAIT
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          state_next = (in_mode == arpc_pkg::MODE_TICK) ? S_TICK : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_next = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_WAIT;
      end
      S_TICK: begin
        // A held result goes out once the next one is found or the walk ends.
        if (sts.tick_more && !(sts.res_pending && sts.slot_hit)) begin
          cmd.tick_step = 1'b1;
        end else if (sts.res_pending) begin
          if (!out_busy) begin
            cmd.emit = 1'b1;
            if (!sts.tick_more) state_next = S_IDLE;
          end
        end else begin
          state_next = S_IDLE;
        end
      end
      S_WAIT: begin
        if (!out_busy) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

### hw/rtl/arpc_dp.sv
// ----------------------------------------------------------------------------
// arpc_dp
// Slot table, configuration registers, lookup scan and result register.
// ----------------------------------------------------------------------------
module arpc_dp #(
  parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_WAITING   = arpc_pkg::MAX_WAITING_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  arpc_pkg::arpc_cmd_t cmd,
  output arpc_pkg::arpc_sts_t sts,
  input  logic [1:0]         mode,
  input  logic [31:0]        ip_addr,
  input  logic [31:0]        dest_ip,
  input  logic [47:0]        src_mac,
  input  logic [15:0]        hw_type,
  input  logic [15:0]        proto_type,
  input  logic [7:0]         hw_len,
  input  logic [7:0]         proto_len,
  input  logic [15:0]        operation,
  input  logic [10:0]        pkt_len,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [63:0]        cfg_wdata,
  output logic [63:0]        cfg_rdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         kind,
  output logic [31:0]        res_ip,
  output logic [47:0]        res_mac,
  output logic [7:0]         waiting_count,
  output logic               last
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [7:0] MAXW = 8'(MAX_WAITING);

  // Configuration.
  logic [31:0] host_ip;
  logic [47:0] host_mac;
  logic [15:0] entry_lifetime;
  logic [7:0]  retry_interval;
  logic [2:0]  max_tries;
  logic [7:0]  holdoff_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      host_ip <= '0; host_mac <= '0; entry_lifetime <= 16'd100;
      retry_interval <= 8'd1; max_tries <= 3'd5; holdoff_time <= 8'd20;
    end else if (cfg_we) begin
      case (cfg_idx)
        arpc_pkg::REG_HOST_IP:  host_ip <= cfg_wdata[31:0];
        arpc_pkg::REG_HOST_MAC: host_mac <= cfg_wdata[47:0];
        arpc_pkg::REG_LIFETIME: entry_lifetime <= cfg_wdata[15:0];
        arpc_pkg::REG_RETRY:    retry_interval <= cfg_wdata[7:0];
        arpc_pkg::REG_TRIES:    max_tries <= cfg_wdata[2:0];
        arpc_pkg::REG_HOLDOFF:  holdoff_time <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      arpc_pkg::REG_HOST_IP:  cfg_rdata = {32'd0, host_ip};
      arpc_pkg::REG_HOST_MAC: cfg_rdata = {16'd0, host_mac};
      arpc_pkg::REG_LIFETIME: cfg_rdata = {48'd0, entry_lifetime};
      arpc_pkg::REG_RETRY:    cfg_rdata = {56'd0, retry_interval};
      arpc_pkg::REG_TRIES:    cfg_rdata = {61'd0, max_tries};
      arpc_pkg::REG_HOLDOFF:  cfg_rdata = {56'd0, holdoff_time};
      default:                cfg_rdata = '0;
    endcase
  end

  // Captured input word.
  logic [1:0]  r_mode;
  logic [31:0] r_ip, r_tip;
  logic [47:0] r_smac;
  logic        r_len_ok, r_type_ok, r_is_req, r_is_rep;

  // Slot table.
  logic [TABLE_ENTRIES-1:0] slot_valid, slot_resolved;
  logic [31:0] slot_ip        [TABLE_ENTRIES];
  logic [47:0] slot_mac       [TABLE_ENTRIES];
  logic [31:0] slot_used_time [TABLE_ENTRIES];
  logic [31:0] slot_send_time [TABLE_ENTRIES];
  logic [2:0]  slot_tries     [TABLE_ENTRIES];
  logic [7:0]  slot_waiting   [TABLE_ENTRIES];
  logic [31:0] seconds_now;

  // Scan state.
  logic [CW-1:0] ptr;
  logic [IW-1:0] idx;
  logic          hit, free_ok;
  logic [IW-1:0] hit_idx, free_idx;
  logic [4:0]    nres;

  assign idx = ptr[IW-1:0];

  // Pending result.
  logic        pend;
  logic [3:0]  p_kind;
  logic [31:0] p_ip;
  logic [47:0] p_mac;
  logic [7:0]  p_wait;

  logic at_end;
  assign at_end = (ptr == CW'(TABLE_ENTRIES));
  assign sts.scan_done   = (ptr == CW'(TABLE_ENTRIES - 1)) || hit;
  assign sts.res_pending = pend;
  assign sts.tick_more   = !at_end && (nres != 5'(arpc_pkg::OUT_LIMIT));

  // Per-slot tick decisions.
  logic [31:0] use_d, send_d;
  logic        age, rtry, hold;
  assign use_d  = seconds_now - slot_used_time[idx];
  assign send_d = seconds_now - slot_send_time[idx];
  assign age  = slot_valid[idx] && (use_d >= {16'd0, entry_lifetime});
  assign rtry = slot_valid[idx] && !slot_resolved[idx] && (slot_tries[idx] < max_tries)
                && (send_d >= {24'd0, retry_interval});
  assign hold = slot_valid[idx] && !slot_resolved[idx] && (slot_tries[idx] >= max_tries)
                && (send_d >= {24'd0, holdoff_time});
  assign sts.slot_hit = age || rtry || hold;

  logic special;
  assign special = (r_ip == arpc_pkg::LOOPBACK_IP) || (r_ip == host_ip);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      slot_resolved <= '0;
      seconds_now <= '0;
      pend <= 1'b0;
      out_valid <= 1'b0;
      ptr <= '0;
      hit <= 1'b0;
      free_ok <= 1'b0;
      nres <= '0;
    end else begin
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      if (cmd.load) begin
        r_mode <= mode; r_ip <= ip_addr; r_tip <= dest_ip; r_smac <= src_mac;
        r_len_ok  <= (pkt_len == arpc_pkg::ARP_LEN);
        r_type_ok <= (proto_type == arpc_pkg::PTYPE_IPV4) && (hw_type == arpc_pkg::HTYPE_ETH)
                     && (proto_len == arpc_pkg::PLEN_IPV4) && (hw_len == arpc_pkg::HLEN_ETH);
        r_is_req  <= (operation == arpc_pkg::OP_REQUEST);
        r_is_rep  <= (operation == arpc_pkg::OP_REPLY);
        if (mode == arpc_pkg::MODE_TICK) seconds_now <= seconds_now + 32'd1;
      end
      if (cmd.scan_clr) begin
        ptr <= '0; hit <= 1'b0; free_ok <= 1'b0; nres <= '0;
      end

      // Lookup walks one slot a cycle, remembering the first free slot.
      if (cmd.scan_step && !hit) begin
        if (slot_valid[idx] && slot_ip[idx] == r_ip) begin
          hit <= 1'b1; hit_idx <= idx;
        end else if (!slot_valid[idx] && !free_ok) begin
          free_ok <= 1'b1; free_idx <= idx;
        end
        if (ptr != CW'(TABLE_ENTRIES - 1)) ptr <= ptr + CW'(1);
      end

      if (cmd.finish) begin
        pend <= 1'b1;
        p_ip <= r_ip; p_mac <= '0; p_wait <= '0; p_kind <= arpc_pkg::K_IGNORED;
        if (r_mode == arpc_pkg::MODE_RESOLVE) begin
          if (special) begin
            p_kind <= arpc_pkg::K_RESOLVED; p_mac <= host_mac;
          end else if (hit) begin
            if (slot_resolved[hit_idx]) begin
              slot_used_time[hit_idx] <= seconds_now;
              p_kind <= arpc_pkg::K_RESOLVED; p_mac <= slot_mac[hit_idx];
            end else if (slot_waiting[hit_idx] < MAXW) begin
              slot_waiting[hit_idx] <= slot_waiting[hit_idx] + 8'd1;
              p_kind <= arpc_pkg::K_QUEUED; p_wait <= slot_waiting[hit_idx] + 8'd1;
            end
          end else if (free_ok) begin
            slot_valid[free_idx] <= 1'b1; slot_resolved[free_idx] <= 1'b0;
            slot_ip[free_idx] <= r_ip; slot_mac[free_idx] <= '0;
            slot_used_time[free_idx] <= seconds_now; slot_send_time[free_idx] <= seconds_now;
            slot_tries[free_idx] <= 3'd1; slot_waiting[free_idx] <= 8'd1;
            p_kind <= arpc_pkg::K_SEND_REQ; p_wait <= 8'd1;
          end else begin
            p_kind <= arpc_pkg::K_FULL;
          end
        end else if (r_mode == arpc_pkg::MODE_PACKET) begin
          if (!r_len_ok) p_kind <= arpc_pkg::K_BAD_LEN;
          else if (!r_type_ok) p_kind <= arpc_pkg::K_BAD_TYPE;
          else if (!r_is_req && !r_is_rep) p_kind <= arpc_pkg::K_BAD_OP;
          else if (r_is_req) begin
            if (r_tip == host_ip) begin
              p_kind <= arpc_pkg::K_SEND_REP; p_mac <= r_smac;
            end else p_kind <= arpc_pkg::K_NOT_ME;
          end else if (hit) begin
            slot_mac[hit_idx] <= r_smac; slot_resolved[hit_idx] <= 1'b1;
            slot_waiting[hit_idx] <= '0; slot_used_time[hit_idx] <= seconds_now;
            p_mac <= r_smac; p_wait <= slot_waiting[hit_idx];
            p_kind <= (slot_waiting[hit_idx] != 8'd0) ? arpc_pkg::K_RELEASE
                                                     : arpc_pkg::K_LEARNED;
          end else if (special) begin
            p_kind <= arpc_pkg::K_IGNORED;
          end else if (free_ok) begin
            slot_valid[free_idx] <= 1'b1; slot_resolved[free_idx] <= 1'b1;
            slot_ip[free_idx] <= r_ip; slot_mac[free_idx] <= r_smac;
            slot_used_time[free_idx] <= seconds_now; slot_send_time[free_idx] <= seconds_now;
            slot_tries[free_idx] <= 3'd1; slot_waiting[free_idx] <= '0;
            p_kind <= arpc_pkg::K_LEARNED; p_mac <= r_smac;
          end else p_kind <= arpc_pkg::K_FULL;
        end else begin
          p_ip <= '0;
        end
      end

      // Tick walks one slot a cycle; a new result waits until the held one is sent.
      if (cmd.tick_step) begin
        ptr <= ptr + CW'(1);
        if (age) begin
          pend <= 1'b1; nres <= nres + 5'd1;
          p_kind <= arpc_pkg::K_AGED; p_ip <= slot_ip[idx];
          p_mac <= slot_resolved[idx] ? slot_mac[idx] : 48'd0;
          p_wait <= slot_waiting[idx];
          slot_valid[idx] <= 1'b0; slot_resolved[idx] <= 1'b0; slot_waiting[idx] <= '0;
        end else if (rtry || hold) begin
          pend <= 1'b1; nres <= nres + 5'd1;
          p_kind <= arpc_pkg::K_SEND_REQ; p_ip <= slot_ip[idx];
          p_mac <= '0; p_wait <= slot_waiting[idx];
          slot_send_time[idx] <= seconds_now;
          slot_tries[idx] <= rtry ? slot_tries[idx] + 3'd1 : 3'd1;
        end
      end

      if (cmd.emit) begin
        pend <= 1'b0;
        kind <= p_kind; res_ip <= p_ip; res_mac <= p_mac; waiting_count <= p_wait;
        // A held tick result is last once no slot remains or the result limit is reached.
        last <= (r_mode != arpc_pkg::MODE_TICK) || !sts.tick_more;
      end
    end
  end

endmodule

### hw/rtl/arpc_checker.sv
// ----------------------------------------------------------------------------
// arpc_checker
// Port-level checks for the address resolution cache.
// ----------------------------------------------------------------------------
module arpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] kind,
  input logic       last
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(last))
    else $error("stalled output word changed");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> kind <= arpc_pkg::K_IGNORED)
    else $error("result kind out of range");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("accepted a word while busy");

endmodule

bind arp_cache_resolver arpc_checker u_arpc_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .kind, .last
);

### tb/tb_arp_cache_resolver.sv
// ----------------------------------------------------------------------------
// tb_arp_cache_resolver
// Self-checking testbench for the address resolution cache. A scoreboard
// class keeps its own copy of the table, the clock and the registers. For
// every accepted input word it predicts the result words, and it checks each
// accepted output word against the oldest prediction. Stimulus is a random
// run at reset defaults, a directed pass, and random resolve, packet and tick
// words over several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [1:0]  mode;
  logic [31:0] ip_addr;
  logic [31:0] dest_ip;
  logic [47:0] src_mac;
  logic [15:0] hw_type;
  logic [15:0] proto_type;
  logic [7:0]  hw_len;
  logic [7:0]  proto_len;
  logic [15:0] operation;
  logic [10:0] pkt_len;
} arp_word_t;

typedef struct packed {
  logic [3:0]  kind;
  logic [31:0] ip;
  logic [47:0] mac;
  logic [7:0]  wcount;
  logic        last;
} arp_result_t;

class arp_scoreboard;
  logic [31:0] host_ip;
  logic [47:0] host_mac;
  logic [15:0] lifetime;
  logic [7:0]  retry_ivl;
  logic [2:0]  max_tries;
  logic [7:0]  holdoff;

  logic        ent_valid[16];
  logic        ent_resolved[16];
  logic [31:0] ent_ip[16];
  logic [47:0] ent_mac[16];
  logic [31:0] ent_used[16];
  logic [31:0] ent_sent[16];
  logic [2:0]  ent_tries[16];
  logic [7:0]  ent_waiting[16];
  logic [31:0] now_sec;

  arp_result_t want_q[$];
  int          errors;

  function new();
    host_ip   = '0;
    host_mac  = '0;
    lifetime  = 16'd100;
    retry_ivl = 8'd1;
    max_tries = 3'd5;
    holdoff   = 8'd20;
    now_sec   = '0;
    errors    = 0;
    for (int i = 0; i < 16; i++) begin
      ent_valid[i]    = 1'b0;
      ent_resolved[i] = 1'b0;
      ent_waiting[i]  = '0;
    end
  endfunction

  function void set_reg(logic [2:0] idx, logic [63:0] v);
    case (idx)
      arpc_pkg::REG_HOST_IP:  host_ip   = v[31:0];
      arpc_pkg::REG_HOST_MAC: host_mac  = v[47:0];
      arpc_pkg::REG_LIFETIME: lifetime  = v[15:0];
      arpc_pkg::REG_RETRY:    retry_ivl = v[7:0];
      arpc_pkg::REG_TRIES:    max_tries = v[2:0];
      arpc_pkg::REG_HOLDOFF:  holdoff   = v[7:0];
      default: ;
    endcase
  endfunction

  function int lookup(logic [31:0] ip);
    for (int i = 0; i < 16; i++)
      if (ent_valid[i] && ent_ip[i] == ip) return i;
    return -1;
  endfunction

  function int free_entry();
    for (int i = 0; i < 16; i++)
      if (!ent_valid[i]) return i;
    return -1;
  endfunction

  function void open_entry(int s, logic [31:0] ip, logic [47:0] mac, logic res,
                           logic [7:0] w);
    ent_valid[s]    = 1'b1;
    ent_resolved[s] = res;
    ent_ip[s]       = ip;
    ent_mac[s]      = mac;
    ent_used[s]     = now_sec;
    ent_sent[s]     = now_sec;
    ent_tries[s]    = 3'd1;
    ent_waiting[s]  = w;
  endfunction

  function arp_result_t mk(logic [3:0] k, logic [31:0] ip, logic [47:0] mac,
                           logic [7:0] w);
    arp_result_t r;
    r.kind = k; r.ip = ip; r.mac = mac; r.wcount = w; r.last = 1'b0;
    return r;
  endfunction

  function arp_result_t resolve(logic [31:0] ip);
    int s;
    if (ip == arpc_pkg::LOOPBACK_IP || ip == host_ip)
      return mk(arpc_pkg::K_RESOLVED, ip, host_mac, 8'd0);
    s = lookup(ip);
    if (s < 0) begin
      s = free_entry();
      if (s < 0) return mk(arpc_pkg::K_FULL, ip, 48'd0, 8'd0);
      open_entry(s, ip, 48'd0, 1'b0, 8'd1);
      return mk(arpc_pkg::K_SEND_REQ, ip, 48'd0, 8'd1);
    end
    if (!ent_resolved[s]) begin
      if (ent_waiting[s] >= 8'd255) return mk(arpc_pkg::K_IGNORED, ip, 48'd0, 8'd0);
      ent_waiting[s] = ent_waiting[s] + 8'd1;
      return mk(arpc_pkg::K_QUEUED, ip, 48'd0, ent_waiting[s]);
    end
    ent_used[s] = now_sec;
    return mk(arpc_pkg::K_RESOLVED, ip, ent_mac[s], 8'd0);
  endfunction

  function arp_result_t packet(arp_word_t w);
    int s;
    logic [7:0] wt;
    if (w.pkt_len != arpc_pkg::ARP_LEN)
      return mk(arpc_pkg::K_BAD_LEN, w.ip_addr, 48'd0, 8'd0);
    if (w.proto_type != arpc_pkg::PTYPE_IPV4 || w.hw_type != arpc_pkg::HTYPE_ETH ||
        w.proto_len != arpc_pkg::PLEN_IPV4 || w.hw_len != arpc_pkg::HLEN_ETH)
      return mk(arpc_pkg::K_BAD_TYPE, w.ip_addr, 48'd0, 8'd0);
    if (w.operation != arpc_pkg::OP_REQUEST && w.operation != arpc_pkg::OP_REPLY)
      return mk(arpc_pkg::K_BAD_OP, w.ip_addr, 48'd0, 8'd0);
    if (w.operation == arpc_pkg::OP_REQUEST) begin
      if (w.dest_ip == host_ip)
        return mk(arpc_pkg::K_SEND_REP, w.ip_addr, w.src_mac, 8'd0);
      return mk(arpc_pkg::K_NOT_ME, w.ip_addr, 48'd0, 8'd0);
    end
    s = lookup(w.ip_addr);
    if (s >= 0) begin
      wt = ent_waiting[s];
      ent_mac[s]      = w.src_mac;
      ent_resolved[s] = 1'b1;
      ent_waiting[s]  = '0;
      ent_used[s]     = now_sec;
      return mk((wt != 8'd0) ? arpc_pkg::K_RELEASE : arpc_pkg::K_LEARNED, w.ip_addr,
                w.src_mac, wt);
    end
    if (w.ip_addr == host_ip || w.ip_addr == arpc_pkg::LOOPBACK_IP)
      return mk(arpc_pkg::K_IGNORED, w.ip_addr, 48'd0, 8'd0);
    s = free_entry();
    if (s < 0) return mk(arpc_pkg::K_FULL, w.ip_addr, 48'd0, 8'd0);
    open_entry(s, w.ip_addr, w.src_mac, 1'b1, 8'd0);
    return mk(arpc_pkg::K_LEARNED, w.ip_addr, w.src_mac, 8'd0);
  endfunction

  // Ages and retries the table; results go straight into the list given.
  function void tick(ref arp_result_t res[$]);
    logic [31:0] use_d, send_d;
    now_sec = now_sec + 32'd1;
    for (int i = 0; i < 16 && res.size() < arpc_pkg::OUT_LIMIT; i++) begin
      if (!ent_valid[i]) continue;
      use_d  = now_sec - ent_used[i];
      send_d = now_sec - ent_sent[i];
      if (use_d >= {16'd0, lifetime}) begin
        res.insert(res.size(), mk(arpc_pkg::K_AGED, ent_ip[i],
                                  ent_resolved[i] ? ent_mac[i] : 48'd0, ent_waiting[i]));
        ent_valid[i]    = 1'b0;
        ent_resolved[i] = 1'b0;
        ent_waiting[i]  = '0;
        continue;
      end
      if (ent_resolved[i]) continue;
      if (ent_tries[i] < max_tries) begin
        if (send_d >= {24'd0, retry_ivl}) begin
          res.insert(res.size(), mk(arpc_pkg::K_SEND_REQ, ent_ip[i], 48'd0, ent_waiting[i]));
          ent_sent[i]  = now_sec;
          ent_tries[i] = ent_tries[i] + 3'd1;
        end
      end else if (send_d >= {24'd0, holdoff}) begin
        res.insert(res.size(), mk(arpc_pkg::K_SEND_REQ, ent_ip[i], 48'd0, ent_waiting[i]));
        ent_sent[i]  = now_sec;
        ent_tries[i] = 3'd1;
      end
    end
  endfunction

  function void note_input(arp_word_t w);
    arp_result_t res[$];
    case (w.mode)
      arpc_pkg::MODE_RESOLVE: res.insert(res.size(), resolve(w.ip_addr));
      arpc_pkg::MODE_PACKET:  res.insert(res.size(), packet(w));
      arpc_pkg::MODE_TICK:    tick(res);
      default: res.insert(res.size(), mk(arpc_pkg::K_IGNORED, 32'd0, 48'd0, 8'd0));
    endcase
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) want_q.insert(want_q.size(), res[i]);
  endfunction

  task report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  task check(arp_result_t got);
    arp_result_t want;
    if (want_q.size() == 0) begin
      report($sformatf("unexpected word kind=%0d ip=%h", got.kind, got.ip));
      return;
    end
    want = want_q.pop_front();
    if (got.kind !== want.kind || got.ip !== want.ip || got.mac !== want.mac ||
        got.wcount !== want.wcount || got.last !== want.last)
      report($sformatf("got k=%0d ip=%h mac=%h w=%0d l=%b want k=%0d ip=%h mac=%h w=%0d l=%b",
                       got.kind, got.ip, got.mac, got.wcount, got.last,
                       want.kind, want.ip, want.mac, want.wcount, want.last));
  endtask
endclass

module tb_arp_cache_resolver;
  timeunit 1ns;
  timeprecision 1ps;

  // Generous ceiling on the run; the slowest correct run is far below it.
  localparam int CYCLE_LIMIT = 600000;
  // Cycles to let a tick walk finish when it may produce no word at all.
  localparam int SETTLE = 40;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [31:0] ip_addr, dest_ip;
  logic [47:0] src_mac;
  logic [15:0] hw_type, proto_type, operation;
  logic [7:0]  hw_len, proto_len;
  logic [10:0] pkt_len;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  kind;
  logic [31:0] res_ip;
  logic [47:0] res_mac;
  logic [7:0]  waiting_count;
  logic        last;

  arp_scoreboard sb = new();
  int  cycles = 0;
  bit  no_gaps = 0;
  bit  no_stalls = 0;
  int  stall_left = 0;

  arp_cache_resolver u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .ip_addr(ip_addr), .dest_ip(dest_ip), .src_mac(src_mac),
    .hw_type(hw_type), .proto_type(proto_type), .hw_len(hw_len), .proto_len(proto_len),
    .operation(operation), .pkt_len(pkt_len),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .res_ip(res_ip), .res_mac(res_mac), .waiting_count(waiting_count),
    .last(last)
  );

  always #1 clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Monitor. Both channels are sampled at the edge with pre-edge values, so the
  // scoreboard sees exactly the words the block accepted and offered.
  always @(posedge clk) begin
    arp_word_t   w;
    arp_result_t r;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        w = '{mode, ip_addr, dest_ip, src_mac, hw_type, proto_type,
              hw_len, proto_len, operation, pkt_len};
        sb.note_input(w);
      end
      if (out_valid && !out_stall) begin
        r = '{kind, res_ip, res_mac, waiting_count, last};
        sb.check(r);
      end
    end
  end

  // Receiver. Each taken word draws a random stall, possibly none, for the next
  // one; every so often the stalls switch off for a stretch.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) no_stalls = ~no_stalls;
      if (out_valid && !out_stall) stall_left = no_stalls ? 0 : $urandom_range(0, 3);
      else if (stall_left > 0) stall_left--;
      out_stall <= (stall_left > 0);
    end
  end

  // Writes one register with a setup phase and then an access phase.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic write_all(input logic [31:0] hip, input logic [47:0] hmac,
                           input logic [15:0] life, input logic [7:0] retry,
                           input logic [2:0] tries, input logic [7:0] hold);
    write_reg(arpc_pkg::REG_HOST_IP, {32'd0, hip});
    write_reg(arpc_pkg::REG_HOST_MAC, {16'd0, hmac});
    write_reg(arpc_pkg::REG_LIFETIME, {48'd0, life});
    write_reg(arpc_pkg::REG_RETRY, {56'd0, retry});
    write_reg(arpc_pkg::REG_TRIES, {61'd0, tries});
    write_reg(arpc_pkg::REG_HOLDOFF, {56'd0, hold});
  endtask

  // Offers one word after a random gap and returns at the edge it is taken.
  task automatic send_word(input arp_word_t w);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= w.mode;
    ip_addr    <= w.ip_addr;
    dest_ip    <= w.dest_ip;
    src_mac    <= w.src_mac;
    hw_type    <= w.hw_type;
    proto_type <= w.proto_type;
    hw_len     <= w.hw_len;
    proto_len  <= w.proto_len;
    operation  <= w.operation;
    pkt_len    <= w.pkt_len;
    do @(posedge clk); while (in_stall);
  endtask

  // Lowers valid and waits until every predicted word has come, plus time for
  // a silent tick walk to finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.want_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [47:0] rand_mac();
    return 48'({$urandom(), $urandom()});
  endfunction

  function automatic arp_word_t noise_word();
    arp_word_t w;
    w.mode       = 2'($urandom());
    w.ip_addr    = $urandom();
    w.dest_ip    = $urandom();
    w.src_mac    = rand_mac();
    w.hw_type    = 16'($urandom());
    w.proto_type = 16'($urandom());
    w.hw_len     = 8'($urandom());
    w.proto_len  = 8'($urandom());
    w.operation  = 16'($urandom());
    w.pkt_len    = 11'($urandom());
    return w;
  endfunction

  function automatic arp_word_t resolve_word(logic [31:0] ip);
    arp_word_t w = noise_word();
    w.mode    = arpc_pkg::MODE_RESOLVE;
    w.ip_addr = ip;
    return w;
  endfunction

  function automatic arp_word_t packet_word(logic [15:0] op, logic [31:0] sip,
                                            logic [31:0] tip, logic [47:0] mac);
    arp_word_t w;
    w.mode       = arpc_pkg::MODE_PACKET;
    w.ip_addr    = sip;
    w.dest_ip    = tip;
    w.src_mac    = mac;
    w.hw_type    = arpc_pkg::HTYPE_ETH;
    w.proto_type = arpc_pkg::PTYPE_IPV4;
    w.hw_len     = arpc_pkg::HLEN_ETH;
    w.proto_len  = arpc_pkg::PLEN_IPV4;
    w.operation  = op;
    w.pkt_len    = arpc_pkg::ARP_LEN;
    return w;
  endfunction

  function automatic arp_word_t tick_word();
    arp_word_t w = noise_word();
    w.mode = arpc_pkg::MODE_TICK;
    return w;
  endfunction

  // Addresses mostly come from a small pool so that lookups hit and the table
  // fills; the host, loopback and arbitrary addresses are mixed in.
  function automatic logic [31:0] pick_ip();
    int r = $urandom_range(0, 99);
    if (r < 80) return {24'h0A0000, 8'($urandom_range(1, 24))};
    if (r < 85) return sb.host_ip;
    if (r < 90) return arpc_pkg::LOOPBACK_IP;
    return $urandom();
  endfunction

  function automatic arp_word_t rand_word();
    arp_word_t w;
    int r = $urandom_range(0, 99);
    int c;
    if (r < 40) return resolve_word(pick_ip());
    if (r < 80) begin
      c = $urandom_range(0, 99);
      w = packet_word((c < 60) ? arpc_pkg::OP_REPLY : arpc_pkg::OP_REQUEST, pick_ip(),
                      ($urandom_range(0, 1) == 1) ? sb.host_ip : pick_ip(), rand_mac());
      // A share of packets carries one broken header field.
      if ($urandom_range(0, 99) < 15) begin
        case ($urandom_range(0, 5))
          0: w.pkt_len    = 11'($urandom());
          1: w.hw_type    = 16'($urandom());
          2: w.proto_type = 16'($urandom());
          3: w.hw_len     = 8'($urandom());
          4: w.proto_len  = 8'($urandom());
          default: w.operation = 16'($urandom());
        endcase
      end
      return w;
    end
    if (r < 97) return tick_word();
    w = noise_word();
    w.mode = arpc_pkg::MODE_UNUSED;
    return w;
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_word(rand_word());
    end
  endtask

  initial begin
    arp_word_t w;
    logic [31:0] hip;
    logic [47:0] hmac;
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid   = 1'b0;
    mode       = '0;
    ip_addr    = '0;
    dest_ip    = '0;
    src_mac    = '0;
    hw_type    = '0;
    proto_type = '0;
    hw_len     = '0;
    proto_len  = '0;
    operation  = '0;
    pkt_len    = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset defaults first.
    run_random(20);
    drain();

    // Directed pass: short lifetime so that aging shows up within a few ticks.
    hip  = 32'h0A00_0001;
    hmac = rand_mac();
    write_all(hip, hmac, 16'd5, 8'd1, 3'd3, 8'd2);
    send_word(resolve_word(arpc_pkg::LOOPBACK_IP));
    send_word(resolve_word(hip));
    send_word(resolve_word(32'h0A00_0005));            // opens a pending entry
    send_word(resolve_word(32'h0A00_0005));            // queues behind it
    send_word(packet_word(arpc_pkg::OP_REPLY, 32'h0A00_0005, hip, 48'hFFFF_FFFF_FFFF));
    send_word(resolve_word(32'h0A00_0005));            // now resolved
    send_word(packet_word(arpc_pkg::OP_REPLY, 32'h0A00_0009, 32'd0, 48'd0));
    send_word(packet_word(arpc_pkg::OP_REPLY, hip, hip, rand_mac()));
    send_word(packet_word(arpc_pkg::OP_REPLY, arpc_pkg::LOOPBACK_IP, hip, rand_mac()));
    send_word(packet_word(arpc_pkg::OP_REQUEST, 32'h0A00_0007, hip, rand_mac()));
    send_word(packet_word(arpc_pkg::OP_REQUEST, 32'h0A00_0007, 32'hFFFF_FFFF, rand_mac()));
    w = packet_word(arpc_pkg::OP_REPLY, 32'h0A00_0003, hip, rand_mac()); w.pkt_len = 11'd0;
    send_word(w);
    w.pkt_len = 11'h7FF;                               send_word(w);
    w = packet_word(arpc_pkg::OP_REPLY, 32'h0A00_0003, hip, rand_mac());
    w.hw_type = 16'hFFFF;
    send_word(w);
    w = packet_word(arpc_pkg::OP_REPLY, 32'h0A00_0003, hip, rand_mac());
    w.proto_type = 16'd0;
    send_word(w);
    w = packet_word(arpc_pkg::OP_REPLY, 32'h0A00_0003, hip, rand_mac()); w.hw_len = 8'hFF;
    send_word(w);
    w = packet_word(arpc_pkg::OP_REPLY, 32'h0A00_0003, hip, rand_mac());
    w.proto_len = 8'd0;
    send_word(w);
    send_word(packet_word(16'd0, 32'h0A00_0003, hip, rand_mac()));
    send_word(packet_word(16'hFFFF, 32'h0A00_0003, hip, rand_mac()));
    send_word(packet_word(16'd3, 32'h0A00_0003, hip, rand_mac()));
    w = noise_word(); w.mode = arpc_pkg::MODE_UNUSED;  send_word(w);
    send_word(resolve_word(32'hFFFF_FFFF));
    send_word(resolve_word(32'd0));
    repeat (4) send_word(tick_word());
    drain();

    run_random(20);
    // The sender holds off here until every predicted word has arrived.
    drain();
    run_random(20);
    drain();

    // Empty the table with a one-second lifetime, then fill it to overflow and
    // queue a run of resolve requests behind one pending entry.
    write_reg(arpc_pkg::REG_LIFETIME, 64'd1);
    send_word(tick_word());
    drain();
    write_all(32'($urandom()), rand_mac(), 16'hFFFF, 8'hFF, 3'd7, 8'hFF);
    for (int i = 0; i < 17; i++) send_word(resolve_word(32'(32'h0A00_0100 + i)));
    for (int i = 0; i < 30; i++) send_word(resolve_word(32'h0A00_0100));
    run_random(20);
    drain();

    write_all(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'd1, 8'd1, 3'd0, 8'd1);
    run_random(20);
    drain();

    // Out-of-range settings are taken as they are.
    write_all(32'd0, 48'd0, 16'd0, 8'd0, 3'd1, 8'd1);
    run_random(20);
    drain();

    write_all(32'h0A00_0002, rand_mac(), 16'd3, 8'd2, 3'd2, 8'd4);
    run_random(20);
    drain();

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

### sim.f
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_ctrl.sv
hw/rtl/arpc_dp.sv
hw/rtl/arp_cache_resolver.sv
hw/rtl/arpc_checker.sv
tb/tb_arp_cache_resolver.sv
